@@ hw/rtl/rplk_pkg.sv @@
// Shared types, constants and constant tables for the radial power-law k-space profile.
// The log2 and exp2 interpolation tables are built at elaboration by constant functions.
// No dependencies.
package rplk_pkg;

  localparam int COORD_WIDTH       = 24;
  localparam int FRAC_BITS         = 16;
  localparam int LOG_TABLE_ENTRIES = 64;

  localparam int EXP_W   = 20;
  localparam int FLUX_W  = 32;
  localparam int CLIP_W  = 32;
  localparam int SCALE_W = 24;
  localparam int VALUE_W = 32;
  localparam int CFG_W   = 32;

  localparam int PROD_W = COORD_WIDTH + SCALE_W;
  localparam int S_W    = 33;
  localparam int P_W    = 6;
  localparam int LUT_W  = $clog2(LOG_TABLE_ENTRIES + 1);
  localparam int LG_W   = 36;
  localparam int Y_W    = EXP_W + LG_W + 1;
  localparam int SH     = FRAC_BITS + 30;
  localparam int N_W    = Y_W - SH;

  localparam logic signed [EXP_W-1:0] EXP_RESET   = -20'sd98304;
  localparam logic [FLUX_W-1:0]       FLUX_RESET  = 32'd65536;
  localparam logic [CLIP_W-1:0]       CLIP_RESET  = 32'hFFFF_FFFF;
  localparam logic [SCALE_W-1:0]      SCALE_RESET = 24'd65536;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  typedef enum logic [1:0] {
    CFG_EXPONENT,
    CFG_FLUX,
    CFG_CLIP,
    CFG_SCALE
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;
    logic                          row_end_in;
  } in_t;

  typedef struct packed {
    logic [VALUE_W-1:0] profile_value;
    logic               was_clipped;
    logic               row_end_out;
  } out_t;

  // Control that travels alongside each word through the pipeline.
  typedef struct packed {
    logic valid;
    logic clipped;
    logic row_end;
  } ctl_t;

  typedef logic [LOG_TABLE_ENTRIES:0][31:0] lut_t;

  // log2 of a Q1.30 value in [1,2) by repeated squaring, result Q0.30.
  function automatic logic [31:0] log2_q30(input logic [63:0] xin);
    logic [63:0] x;
    logic [31:0] r;
    x = xin;
    r = '0;
    if (x >= 2 * Q30_ONE) return Q30_ONE[31:0];
    if (x < Q30_ONE) return '0;
    for (int k = 0; k < 30; k++) begin
      x = (x * x) >> 30;
      r = {r[30:0], 1'b0};
      if (x >= 2 * Q30_ONE) begin
        r[0] = 1'b1;
        x = x >> 1;
      end
    end
    return r;
  endfunction

  function automatic lut_t build_log_tab();
    lut_t t;
    logic [63:0] target;
    for (int i = 0; i <= LOG_TABLE_ENTRIES; i++) begin
      target = (64'(i) << 30) / LOG_TABLE_ENTRIES;
      t[i] = log2_q30(Q30_ONE + target);
    end
    return t;
  endfunction

  // Smallest Q1.30 value whose log2 reaches each segment boundary.
  function automatic lut_t build_exp_tab();
    lut_t t;
    logic [63:0] target;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    t[0] = Q30_ONE[31:0];
    for (int i = 1; i <= LOG_TABLE_ENTRIES; i++) begin
      target = (64'(i) << 30) / LOG_TABLE_ENTRIES;
      lo = Q30_ONE;
      hi = 2 * Q30_ONE;
      for (int it = 0; it < 32; it++) begin
        if (hi - lo > 64'd1) begin
          mid = (lo + hi) >> 1;
          if (64'(log2_q30(mid)) < target) lo = mid;
          else hi = mid;
        end
      end
      t[i] = hi[31:0];
    end
    return t;
  endfunction

  localparam lut_t LOG_TAB = build_log_tab();
  localparam lut_t EXP_TAB = build_exp_tab();

endpackage

@@ hw/rtl/rplk_square.sv @@
// Stages 1 to 3: coordinate scaling, squaring, clip test and base s = 1 + ksq.
// Depends on rplk_pkg.
module rplk_square
  import rplk_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  ctl_t                          ctl_in,
  input  logic signed [COORD_WIDTH-1:0] coord_x,
  input  logic signed [COORD_WIDTH-1:0] coord_y,
  input  logic [SCALE_W-1:0]            radius_scale,
  input  logic [CLIP_W-1:0]             clip_ksq_limit,
  output ctl_t                          ctl_out,
  output logic [S_W-1:0]                s
);

  logic [COORD_WIDTH-1:0] mag_x, mag_y;
  logic [PROD_W-1:0] px, py;
  logic [PROD_W-1:0] axs, ays;
  logic [31:0] ax, ay;
  logic [63:0] sqx, sqy;
  logic [64:0] ksq;
  logic huge, huge_now;
  ctl_t c1, c2;

  always_comb begin
    mag_x = coord_x[COORD_WIDTH-1] ? (~coord_x + 1'b1) : coord_x;
    mag_y = coord_y[COORD_WIDTH-1] ? (~coord_y + 1'b1) : coord_y;
    axs = px >> FRAC_BITS;
    ays = py >> FRAC_BITS;
    ax = axs[31:0];
    ay = ays[31:0];
    huge_now = ((axs >> 32) != '0) || ((ays >> 32) != '0);
    ksq = {1'b0, sqx >> FRAC_BITS} + {1'b0, sqy >> FRAC_BITS};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
      ctl_out <= '0;
    end else if (adv) begin
      c1 <= ctl_in;
      c2 <= c1;
      ctl_out <= '{valid: c2.valid,
                   clipped: c2.clipped || huge || (ksq > 65'(clip_ksq_limit)),
                   row_end: c2.row_end};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px <= PROD_W'(mag_x) * PROD_W'(radius_scale);
      py <= PROD_W'(mag_y) * PROD_W'(radius_scale);
      huge <= huge_now;
      sqx <= 64'(ax) * 64'(ax);
      sqy <= 64'(ay) * 64'(ay);
      s <= ksq[S_W-1:0] + (S_W'(1) << FRAC_BITS);
    end
  end

endmodule

@@ hw/rtl/rplk_log2.sv @@
// Stages 4 to 6: leading-one search, table lookup with interpolation, log2 of s in Q.30.
// Depends on rplk_pkg.
module rplk_log2
  import rplk_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  ctl_t            ctl_in,
  input  logic [S_W-1:0]  s,
  output ctl_t            ctl_out,
  output logic [LG_W-1:0] lg
);

  logic [P_W-1:0] p_now, p4, p5;
  logic [S_W+31:0] norm;
  logic [31:0] f;
  logic [63:0] seg;
  logic [LUT_W-1:0] idx;
  logic [31:0] frac, lo_now, diff;
  logic [63:0] ip;
  logic [31:0] lo, ifrac;
  ctl_t c4, c5;

  always_comb begin
    p_now = '0;
    for (int b = 0; b < S_W; b++) begin
      if (s[b]) p_now = P_W'(b);
    end
    norm = {s, 32'b0} >> p_now;
    seg = 64'(f) * 64'(LOG_TABLE_ENTRIES);
    idx = seg[32+LUT_W-1:32];
    frac = seg[31:0];
    lo_now = LOG_TAB[idx];
    diff = LOG_TAB[LUT_W'(idx + 1'b1)] - lo_now;
    ip = 64'(diff) * 64'(frac);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c4 <= '0;
      c5 <= '0;
      ctl_out <= '0;
    end else if (adv) begin
      c4 <= ctl_in;
      c5 <= c4;
      ctl_out <= c5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p4 <= p_now;
      f <= norm[31:0];
      p5 <= p4;
      lo <= lo_now;
      ifrac <= ip[63:32];
      lg <= LG_W'(lo) + LG_W'(ifrac) + ((LG_W'(p5) - LG_W'(FRAC_BITS)) << 30);
    end
  end

endmodule

@@ hw/rtl/rplk_exp2.sv @@
// Stages 7 to 9: exponent times log2, floor split, exp2 table lookup with interpolation.
// Depends on rplk_pkg.
module rplk_exp2
  import rplk_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  ctl_t                    ctl_in,
  input  logic [LG_W-1:0]         lg,
  input  logic signed [EXP_W-1:0] power_exponent,
  output ctl_t                    ctl_out,
  output logic signed [N_W-1:0]   n,
  output logic [31:0]             mant
);

  logic signed [Y_W-1:0] y;
  logic signed [Y_W-1:0] y_sh;
  logic [29:0] g;
  logic [63:0] seg;
  logic [LUT_W-1:0] idx;
  logic [29:0] frac;
  logic [31:0] lo_now, diff;
  logic [63:0] ip;
  logic [31:0] lo, ifrac;
  logic signed [N_W-1:0] n8;
  ctl_t c7, c8;

  always_comb begin
    // Arithmetic shift gives the floor; the low bits are then the positive fraction.
    y_sh = y >>> SH;
    g = y[SH-1:FRAC_BITS];
    seg = 64'(g) * 64'(LOG_TABLE_ENTRIES);
    idx = seg[30+LUT_W-1:30];
    frac = seg[29:0];
    lo_now = EXP_TAB[idx];
    diff = EXP_TAB[LUT_W'(idx + 1'b1)] - lo_now;
    ip = 64'(diff) * 64'(frac);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c7 <= '0;
      c8 <= '0;
      ctl_out <= '0;
    end else if (adv) begin
      c7 <= ctl_in;
      c8 <= c7;
      ctl_out <= c8;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      y <= Y_W'(power_exponent) * $signed({1'b0, lg});
      n8 <= y_sh[N_W-1:0];
      lo <= lo_now;
      ifrac <= ip[61:30];
      n <= n8;
      mant <= lo + ifrac;
    end
  end

endmodule

@@ hw/rtl/rplk_scale.sv @@
// Stages 10 and 11: flux times mantissa, shift by the integer power, saturate, output register.
// Depends on rplk_pkg.
module rplk_scale
  import rplk_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  ctl_t                  ctl_in,
  input  logic signed [N_W-1:0] n,
  input  logic [31:0]           mant,
  input  logic [FLUX_W-1:0]     total_flux,
  output logic                  out_valid,
  output out_t                  out_word
);

  localparam logic [VALUE_W-1:0] SAT = '1;

  ctl_t c10;
  logic signed [N_W-1:0] n10;
  logic [63:0] prod;
  logic signed [N_W+1:0] rs, ls;
  logic [63:0] shr;
  logic [VALUE_W-1:0] val;

  always_comb begin
    rs = (N_W+2)'(30) - (N_W+2)'(n10);
    ls = (N_W+2)'(n10) - (N_W+2)'(30);
    shr = prod >> rs[5:0];
    val = '0;
    if (rs >= 0) begin
      if (rs >= 64) val = '0;
      else if ((shr >> 32) != '0) val = SAT;
      else val = shr[31:0];
    end else if (prod == '0) begin
      val = '0;
    end else if (ls >= 32) begin
      val = SAT;
    end else if ((prod >> (6'd32 - ls[5:0])) != '0) begin
      val = SAT;
    end else begin
      val = VALUE_W'(prod << ls[5:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c10 <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      c10 <= ctl_in;
      out_valid <= c10.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n10 <= n;
      prod <= 64'(total_flux) * 64'(mant);
      out_word.profile_value <= c10.clipped ? '0 : val;
      out_word.was_clipped <= c10.clipped;
      out_word.row_end_out <= c10.row_end;
    end
  end

endmodule

@@ hw/rtl/radial_power_law_kspace_profile.sv @@
// Radial power-law k-space profile: flux * (1 + kx^2 + ky^2)^exponent in fixed point.
// Top level; depends on rplk_pkg, rplk_square, rplk_log2, rplk_exp2 and rplk_scale.
//
// Usage:
//   Input words (coord_x, coord_y, row_end_in) arrive on in_valid/in_word and are taken
//   at a clock edge where in_valid is high and in_stall is low. Result words leave on
//   out_valid/out_word and are taken where out_valid is high and out_stall is low.
//   The pipeline has eleven register stages; when nothing stalls, one word enters and
//   one leaves every cycle. Latency is set by the two table interpolations and the four
//   multiplier stages. When the receiver stalls a valid result, the whole pipeline
//   holds in place and in_stall goes high in the same cycle; nothing is lost or
//   repeated. The user must write configuration (cfg_we, cfg_index, cfg_data) only
//   while no word is in flight; the block does not enforce this. Reset clears all stage
//   valid bits and loads exponent -1.5, flux 1.0, clip limit all ones and scale 1.0.
//   There is no clearing pass after reset. Clipped pixels give a zero value with
//   was_clipped set; values saturate at all ones.
module radial_power_law_kspace_profile
  import rplk_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_t              in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output out_t             out_word,
  input  logic             cfg_we,
  input  cfg_idx_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic signed [EXP_W-1:0] power_exponent;
  logic [FLUX_W-1:0] total_flux;
  logic [CLIP_W-1:0] clip_ksq_limit;
  logic [SCALE_W-1:0] radius_scale;

  logic adv;
  ctl_t ctl_in, ctl_sq, ctl_lg, ctl_ex;
  logic [S_W-1:0] s;
  logic [LG_W-1:0] lg;
  logic signed [N_W-1:0] n;
  logic [31:0] mant;

  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign ctl_in = '{valid: in_valid, clipped: 1'b0, row_end: in_word.row_end_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      power_exponent <= EXP_RESET;
      total_flux <= FLUX_RESET;
      clip_ksq_limit <= CLIP_RESET;
      radius_scale <= SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXPONENT: power_exponent <= cfg_data[EXP_W-1:0];
        CFG_FLUX:     total_flux <= cfg_data[FLUX_W-1:0];
        CFG_CLIP:     clip_ksq_limit <= cfg_data[CLIP_W-1:0];
        CFG_SCALE:    radius_scale <= cfg_data[SCALE_W-1:0];
        default:      ;
      endcase
    end
  end

  rplk_square u_square (
    .clk(clk), .rst(rst), .adv(adv), .ctl_in(ctl_in),
    .coord_x(in_word.coord_x), .coord_y(in_word.coord_y),
    .radius_scale(radius_scale), .clip_ksq_limit(clip_ksq_limit),
    .ctl_out(ctl_sq), .s(s)
  );

  rplk_log2 u_log2 (
    .clk(clk), .rst(rst), .adv(adv), .ctl_in(ctl_sq), .s(s),
    .ctl_out(ctl_lg), .lg(lg)
  );

  rplk_exp2 u_exp2 (
    .clk(clk), .rst(rst), .adv(adv), .ctl_in(ctl_lg), .lg(lg),
    .power_exponent(power_exponent), .ctl_out(ctl_ex), .n(n), .mant(mant)
  );

  rplk_scale u_scale (
    .clk(clk), .rst(rst), .adv(adv), .ctl_in(ctl_ex), .n(n), .mant(mant),
    .total_flux(total_flux), .out_valid(out_valid), .out_word(out_word)
  );

  a_clip_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.was_clipped |-> out_word.profile_value == '0)
    else $error("clipped word carries a nonzero value");

  a_zero_flux: assert property (@(posedge clk) disable iff (rst)
    out_valid && total_flux == '0 |-> out_word.profile_value == '0)
    else $error("zero flux gave a nonzero value");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid)
    else $error("output valid right after reset");

endmodule

@@ tb/tb_radial_power_law_kspace_profile.sv @@
// Self-checking bench for the radial power-law k-space profile block.
// Drives random pixel words with bursts, gaps and receiver stalls; predicts every result.
// Depends on rplk_pkg and radial_power_law_kspace_profile.
module tb_radial_power_law_kspace_profile;
  import rplk_pkg::*;

  localparam int TAB_N = 64;
  localparam int DRAIN_CYCLES = 20;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD = 400;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam logic [63:0] MASK32 = 64'hFFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_word;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_EXPONENT;
  logic [CFG_W-1:0] cfg_data = '0;

  radial_power_law_kspace_profile dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Local copy of the block's registers.
  logic [19:0] exp_reg = 20'hE8000;
  logic [31:0] flux_reg = 32'd65536;
  logic [31:0] clip_reg = 32'hFFFF_FFFF;
  logic [23:0] scale_reg = 24'd65536;

  logic [31:0] log_lut [0:TAB_N];
  logic [31:0] exp_lut [0:TAB_N];

  in_t pixel_queue[$];
  out_t pending_profiles[$];
  int errors = 0;
  logic hold_send = 1'b1;

  // log2 of a Q1.30 value in [1,2] by squaring, Q0.30 result.
  function automatic logic [31:0] frac_log2(logic [63:0] xin);
    logic [63:0] x;
    logic [31:0] r;
    x = xin;
    r = '0;
    if (x >= 2 * ONE_Q30) return ONE_Q30[31:0];
    if (x < ONE_Q30) return '0;
    for (int k = 0; k < 30; k++) begin
      x = (x * x) >> 30;
      r = r << 1;
      if (x >= 2 * ONE_Q30) begin
        r[0] = 1'b1;
        x = x >> 1;
      end
    end
    return r;
  endfunction

  task automatic build_luts();
    logic [63:0] target, lo, hi, mid;
    for (int i = 0; i <= TAB_N; i++) begin
      target = (64'(i) << 30) / TAB_N;
      log_lut[i] = frac_log2(ONE_Q30 + target);
      lo = ONE_Q30;
      hi = 2 * ONE_Q30;
      while (hi - lo > 1) begin
        mid = (lo + hi) >> 1;
        if (64'(frac_log2(mid)) < target) lo = mid;
        else hi = mid;
      end
      exp_lut[i] = (i == 0) ? ONE_Q30[31:0] : hi[31:0];
    end
  endtask

  function automatic logic [63:0] flux_power(logic [63:0] ksq);
    logic [63:0] s, f, seg, idx, r, lg, g, mant, prod, uy, q, rr;
    logic [63:0] mask46;
    longint y, n, ex;
    int p;
    mask46 = (64'd1 << 46) - 1;
    s = 64'd65536 + ksq;
    p = 63;
    while (p > 0 && s[p] == 1'b0) p--;
    f = (p >= 32) ? ((s >> (p - 32)) & MASK32) : ((s << (32 - p)) & MASK32);
    seg = f * TAB_N;
    idx = seg >> 32;
    r = seg & MASK32;
    lg = log_lut[idx] + (((64'(log_lut[idx + 1]) - log_lut[idx]) * r) >> 32);
    lg = lg + (64'(p - 16) << 30);
    ex = longint'($signed(exp_reg));
    y = ex * longint'(lg);
    if (y >= 0) begin
      n = y >>> 46;
      g = 64'(y) & mask46;
    end else begin
      uy = 64'(-y);
      q = uy >> 46;
      rr = uy & mask46;
      if (rr == 0) begin
        n = -longint'(q);
        g = 0;
      end else begin
        n = -longint'(q) - 1;
        g = (64'd1 << 46) - rr;
      end
    end
    g = g >> 16;
    seg = g * TAB_N;
    idx = seg >> 30;
    r = seg & (ONE_Q30 - 1);
    mant = exp_lut[idx] + (((64'(exp_lut[idx + 1]) - exp_lut[idx]) * r) >> 30);
    prod = 64'(flux_reg) * mant;
    if (n <= 30) begin
      if (30 - n >= 64) return 0;
      return prod >> (30 - n);
    end
    if (prod == 0) return 0;
    if (n - 30 >= 32 || prod > (MASK32 >> (n - 30))) return MASK32;
    return prod << (n - 30);
  endfunction

  function automatic out_t predict_pixel(in_t w);
    out_t res;
    longint cx, cy;
    logic [63:0] ax, ay, ksq, val;
    cx = longint'($signed(w.coord_x));
    cy = longint'($signed(w.coord_y));
    ax = (64'(cx < 0 ? -cx : cx) * scale_reg) >> 16;
    ay = (64'(cy < 0 ? -cy : cy) * scale_reg) >> 16;
    val = 0;
    res.was_clipped = 1'b0;
    if (ax > MASK32 || ay > MASK32) begin
      res.was_clipped = 1'b1;
    end else begin
      ksq = ((ax * ax) >> 16) + ((ay * ay) >> 16);
      res.was_clipped = ksq > clip_reg;
      if (!res.was_clipped) val = flux_power(ksq);
    end
    res.profile_value = (val > MASK32) ? 32'hFFFF_FFFF : val[31:0];
    res.row_end_out = w.row_end_in;
    return res;
  endfunction

  function automatic logic [23:0] rand_coord();
    logic [23:0] v;
    case ($urandom_range(0, 3))
      0: v = 24'($urandom);
      1: v = 24'($urandom_range(0, 1 << 17));
      2: v = 24'($urandom_range(0, 1 << 12));
      default: begin
        case ($urandom_range(0, 3))
          0: v = 24'h7FFFFF;
          1: v = 24'h800000;
          2: v = 24'd1;
          default: v = '0;
        endcase
      end
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  task automatic add_pixel(logic [23:0] x, logic [23:0] y, logic re);
    in_t w;
    w.coord_x = x;
    w.coord_y = y;
    w.row_end_in = re;
    pixel_queue.push_back(w);
  endtask

  // Registers change only while nothing is in flight.
  task automatic set_config(logic [19:0] e, logic [31:0] f, logic [31:0] c, logic [23:0] s);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_EXPONENT;
    cfg_data <= 32'(e);
    @(posedge clk);
    cfg_index <= CFG_FLUX;
    cfg_data <= f;
    @(posedge clk);
    cfg_index <= CFG_CLIP;
    cfg_data <= c;
    @(posedge clk);
    cfg_index <= CFG_SCALE;
    cfg_data <= 32'(s);
    @(posedge clk);
    cfg_we <= 1'b0;
    exp_reg = e;
    flux_reg = f;
    clip_reg = c;
    scale_reg = s;
  endtask

  task automatic run_phase();
    hold_send = 1'b0;
    wait (pixel_queue.size() == 0 && !in_valid && pending_profiles.size() == 0);
    hold_send = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pixel_queue.size() > 0 && !hold_send) begin
        in_word <= pixel_queue.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall density changes now and then, plus one long hold-off that starts
  // while the sender is offering words, so that the pipeline fills up.
  int rx_cycle = 0;
  int rx_mode = 0;
  int rx_mode_left = 0;
  int rx_hold = 0;
  logic long_done = 1'b0;
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (!long_done && rx_cycle >= 1000 && in_valid) begin
      long_done <= 1'b1;
      rx_hold <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_stall <= 1'b1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode <= $urandom_range(0, 2);
        rx_mode_left <= $urandom_range(32, 400);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Prediction at input acceptance, checking at output acceptance.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) pending_profiles.push_back(predict_pixel(in_word));
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_profiles.size() == 0) begin
        $display("%0t: unexpected word, got %h", $time, out_word);
        errors = errors + 1;
      end else begin
        want = pending_profiles.pop_front();
        if (want.profile_value !== out_word.profile_value) begin
          $display("%0t: profile_value expected %h got %h", $time,
                   want.profile_value, out_word.profile_value);
          errors = errors + 1;
        end
        if (want.was_clipped !== out_word.was_clipped) begin
          $display("%0t: was_clipped expected %b got %b", $time,
                   want.was_clipped, out_word.was_clipped);
          errors = errors + 1;
        end
        if (want.row_end_out !== out_word.row_end_out) begin
          $display("%0t: row_end_out expected %b got %b", $time,
                   want.row_end_out, out_word.row_end_out);
          errors = errors + 1;
        end
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [19:0] e;
    logic [31:0] f, c;
    logic [23:0] s;
    build_luts();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: zero, extremes of both axes, the row marker.
    add_pixel(24'd0, 24'd0, 1'b0);
    add_pixel(24'd0, 24'd0, 1'b1);
    add_pixel(24'h7FFFFF, 24'h7FFFFF, 1'b0);
    add_pixel(24'h800000, 24'h800000, 1'b1);
    add_pixel(24'h800000, 24'h7FFFFF, 1'b0);
    add_pixel(24'd1, -24'd1, 1'b0);
    add_pixel(24'd65536, 24'd0, 1'b0);
    add_pixel(24'd0, -24'd65536, 1'b1);
    add_pixel(24'h100000, 24'h100000, 1'b0);
    add_pixel(24'hAAAAAA, 24'h555555, 1'b1);
    run_phase();

    // Steepest exponent, full flux, tight clip, largest scale.
    set_config(-20'sd327680, 32'hFFFF_FFFF, 32'd0, 24'hFFFFFF);
    add_pixel(24'd0, 24'd0, 1'b0);
    add_pixel(24'd1, 24'd0, 1'b1);
    add_pixel(24'h7FFFFF, 24'h800000, 1'b0);
    run_phase();

    // Positive exponent drives the result into saturation.
    set_config(20'h7FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'd65536);
    add_pixel(24'd0, 24'd0, 1'b0);
    add_pixel(24'd65536, 24'd65536, 1'b1);
    add_pixel(24'h7FFFFF, 24'h7FFFFF, 1'b0);
    run_phase();

    // Shallowest exponent, zero scale, zero flux, then a tiny power underflowing.
    set_config(-20'sd9830, 32'd0, 32'd1000, 24'd0);
    add_pixel(24'h7FFFFF, 24'h800000, 1'b1);
    add_pixel(24'd12345, 24'd0, 1'b0);
    run_phase();
    set_config(-20'sd327680, 32'd1, 32'hFFFF_FFFF, 24'd65536);
    add_pixel(24'h7FFFFF, 24'h7FFFFF, 1'b0);
    add_pixel(24'd300, 24'd0, 1'b1);
    run_phase();

    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 4))
        0: e = -20'sd327680;
        1: e = -20'sd9830;
        2: e = 20'($urandom);
        3: e = -20'sd98304;
        default: e = -20'($urandom_range(9830, 327680));
      endcase
      case ($urandom_range(0, 3))
        0: f = 32'd0;
        1: f = 32'hFFFF_FFFF;
        2: f = 32'd65536;
        default: f = $urandom;
      endcase
      case ($urandom_range(0, 3))
        0: c = 32'hFFFF_FFFF;
        1: c = 32'd0;
        2: c = $urandom;
        default: c = $urandom_range(0, 1 << 20);
      endcase
      case ($urandom_range(0, 4))
        0: s = 24'd65536;
        1: s = 24'd0;
        2: s = 24'hFFFFFF;
        3: s = 24'($urandom);
        default: s = 24'($urandom_range(0, 1 << 17));
      endcase
      set_config(e, f, c, s);
      for (int i = 0; i < 200; i++) add_pixel(rand_coord(), rand_coord(), 1'($urandom));
      run_phase();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_profiles.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
